@@ hw/rtl/ipv6p_pkg.sv @@
// Shared types and constants for the IPv6 text address parser.
package ipv6p_pkg;

    localparam int NUM_GROUPS  = 8;
    localparam int GROUP_W     = 16;
    localparam int GIDX_W      = $clog2(NUM_GROUPS);
    localparam int GCNT_W      = $clog2(NUM_GROUPS + 1);
    localparam int MAX_DIGITS  = 4;
    localparam int DCNT_W      = 3;

    // Character queue between classifier and parser; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        TOK_HEX,
        TOK_COLON,
        TOK_SPACE,
        TOK_OTHER
    } tok_kind_t;

    typedef enum logic [1:0] {
        PREV_START,
        PREV_HEX,
        PREV_COLON,
        PREV_DCOLON
    } prev_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [3:0]  value;
        logic        last;
    } token_t;

endpackage

@@ hw/rtl/ipv6p_front.sv @@
// Character classifier and token queue in front of the parser.
module ipv6p_front
    import ipv6p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       tok_valid,
    output token_t     tok,
    input  logic       tok_pop
);

    token_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  push;
    token_t                tok_in;

    always_comb
    begin
        tok_in.last  = last_char;
        tok_in.value = 4'h0;
        case (char_code) inside
            [8'h30:8'h39]:
            begin
                tok_in.kind  = TOK_HEX;
                tok_in.value = char_code[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]:
            begin
                tok_in.kind  = TOK_HEX;
                tok_in.value = char_code[3:0] + 4'd9;
            end
            CHAR_COLON:
            begin
                tok_in.kind = TOK_COLON;
            end
            CHAR_SPACE:
            begin
                tok_in.kind = TOK_SPACE;
            end
            default:
            begin
                tok_in.kind = TOK_OTHER;
            end
        endcase
    end

    assign char_stall = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign push       = char_valid && !char_stall;
    assign tok_valid  = (count_reg != '0);
    assign tok        = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !tok_pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (!push && tok_pop)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (tok_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("token queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("token popped from empty queue");

endmodule

@@ hw/rtl/ipv6p_back.sv @@
// Group parser, address assembly and result register.
module ipv6p_back
    import ipv6p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    input  token_t      tok,
    output logic        tok_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low,
    output logic        addr_valid
);

    logic [GROUP_W-1:0] store_reg  [NUM_GROUPS];
    logic [GROUP_W-1:0] store_next [NUM_GROUPS];
    logic [GROUP_W-1:0] accum_reg;
    logic [GROUP_W-1:0] accum_next;
    logic [DCNT_W-1:0]  digit_cnt_reg;
    logic [DCNT_W-1:0]  digit_cnt_next;
    logic [GCNT_W-1:0]  groups_reg;
    logic [GCNT_W-1:0]  groups_next;
    logic [GCNT_W-1:0]  gap_idx_reg;
    logic [GCNT_W-1:0]  gap_idx_next;
    logic               gap_seen_reg;
    logic               gap_seen_next;
    prev_kind_t         prev_reg;
    prev_kind_t         prev_next;
    logic               err_reg;
    logic               err_next;
    logic               stop_reg;
    logic               stop_next;

    logic [GROUP_W-1:0] fin_store [NUM_GROUPS];
    logic [GROUP_W-1:0] addr_grp  [NUM_GROUPS];
    logic [GCNT_W-1:0]  fin_groups;
    logic               fin_err;
    logic [GCNT_W-1:0]  shift;

    logic               result_valid_reg;
    logic [63:0]        addr_high_reg;
    logic [63:0]        addr_low_reg;
    logic               addr_valid_reg;
    logic               out_free;
    logic               finish;

    assign out_free = !result_valid_reg || !result_stall;
    assign tok_pop  = tok_valid && (!tok.last || out_free);
    assign finish   = tok_pop && tok.last;

    // Consume one token into the parse state.
    always_comb
    begin
        store_next     = store_reg;
        accum_next     = accum_reg;
        digit_cnt_next = digit_cnt_reg;
        groups_next    = groups_reg;
        gap_idx_next   = gap_idx_reg;
        gap_seen_next  = gap_seen_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        stop_next      = stop_reg;
        if (tok_pop && !err_reg && !stop_reg)
        begin
            unique case (tok.kind)
                TOK_SPACE:
                begin
                    stop_next = 1'b1;
                end
                TOK_COLON:
                begin
                    unique case (prev_reg)
                        PREV_START:
                        begin
                            prev_next = PREV_COLON;
                        end
                        PREV_HEX:
                        begin
                            if (groups_reg >= GCNT_W'(NUM_GROUPS))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                store_next[groups_reg[GIDX_W-1:0]] = accum_reg;
                                groups_next    = groups_reg + GCNT_W'(1);
                                accum_next     = '0;
                                digit_cnt_next = '0;
                            end
                            prev_next = PREV_COLON;
                        end
                        PREV_COLON:
                        begin
                            if (gap_seen_reg)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                gap_seen_next = 1'b1;
                                gap_idx_next  = groups_reg;
                                prev_next     = PREV_DCOLON;
                            end
                        end
                        PREV_DCOLON:
                        begin
                            err_next = 1'b1;
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
                TOK_HEX:
                begin
                    if (prev_reg == PREV_COLON && groups_reg == '0 && !gap_seen_reg)
                    begin
                        // leading single colon
                        err_next = 1'b1;
                    end
                    else if (prev_reg == PREV_HEX)
                    begin
                        if (digit_cnt_reg >= DCNT_W'(MAX_DIGITS))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            accum_next     = {accum_reg[GROUP_W-5:0], tok.value};
                            digit_cnt_next = digit_cnt_reg + DCNT_W'(1);
                        end
                    end
                    else
                    begin
                        accum_next     = GROUP_W'(tok.value);
                        digit_cnt_next = DCNT_W'(1);
                        prev_next      = PREV_HEX;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    // Close the last group, check the group count and expand the gap.
    always_comb
    begin
        fin_store  = store_next;
        fin_groups = groups_next;
        fin_err    = err_next;
        if (!err_next)
        begin
            if (prev_next == PREV_HEX)
            begin
                if (groups_next >= GCNT_W'(NUM_GROUPS))
                begin
                    fin_err = 1'b1;
                end
                else
                begin
                    fin_store[groups_next[GIDX_W-1:0]] = accum_next;
                    fin_groups = groups_next + GCNT_W'(1);
                end
            end
            else if (prev_next != PREV_DCOLON)
            begin
                fin_err = 1'b1;
            end
        end
        if (!fin_err)
        begin
            if (gap_seen_next ? (fin_groups > GCNT_W'(NUM_GROUPS - 1))
                              : (fin_groups != GCNT_W'(NUM_GROUPS)))
            begin
                fin_err = 1'b1;
            end
        end
        shift = GCNT_W'(NUM_GROUPS) - fin_groups;
        for (int p = 0; p < NUM_GROUPS; p++)
        begin
            if (!gap_seen_next || GCNT_W'(p) < gap_idx_next)
            begin
                addr_grp[p] = fin_store[p];
            end
            else if ({1'b0, GCNT_W'(p)} >= ({1'b0, gap_idx_next} + {1'b0, shift}))
            begin
                addr_grp[p] = fin_store[GIDX_W'(GCNT_W'(p) - shift)];
            end
            else
            begin
                addr_grp[p] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            store_reg <= store_next;
        end
        if (finish)
        begin
            addr_high_reg <= fin_err ? 64'd0
                           : {addr_grp[0], addr_grp[1], addr_grp[2], addr_grp[3]};
            addr_low_reg  <= fin_err ? 64'd0
                           : {addr_grp[4], addr_grp[5], addr_grp[6], addr_grp[7]};
            addr_valid_reg <= !fin_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg        <= '0;
            digit_cnt_reg    <= '0;
            groups_reg       <= '0;
            gap_idx_reg      <= '0;
            gap_seen_reg     <= 1'b0;
            prev_reg         <= PREV_START;
            err_reg          <= 1'b0;
            stop_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                // start over for the next address text
                accum_reg     <= '0;
                digit_cnt_reg <= '0;
                groups_reg    <= '0;
                gap_idx_reg   <= '0;
                gap_seen_reg  <= 1'b0;
                prev_reg      <= PREV_START;
                err_reg       <= 1'b0;
                stop_reg      <= 1'b0;
            end
            else
            begin
                accum_reg     <= accum_next;
                digit_cnt_reg <= digit_cnt_next;
                groups_reg    <= groups_next;
                gap_idx_reg   <= gap_idx_next;
                gap_seen_reg  <= gap_seen_next;
                prev_reg      <= prev_next;
                err_reg       <= err_next;
                stop_reg      <= stop_next;
            end
            if (finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign addr_high    = addr_high_reg;
    assign addr_low     = addr_low_reg;
    assign addr_valid   = addr_valid_reg;

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= DCNT_W'(MAX_DIGITS))
        else $error("group digit count out of range");

    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gap_idx_reg <= groups_reg)
        else $error("gap position beyond completed groups");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !addr_valid_reg) |-> (addr_high_reg == 64'd0 && addr_low_reg == 64'd0))
        else $error("rejected address carries nonzero data");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (groups_reg == '0 && prev_reg == PREV_START && !err_reg && !stop_reg))
        else $error("parser did not restart after last character");

endmodule

@@ hw/rtl/ipv6_text_address_parser_top.sv @@
// Top level of the IPv6 text address parser.
//
// Input channel: one ASCII character per transaction on char_code, with
// last_char high on the final character of an address text. A transaction
// completes when char_valid is high and char_stall is low.
// Output channel: one transaction per text, on the edge after its last
// character is parsed: addr_high/addr_low hold the 128-bit address (first
// group in the top bits, double-colon gap filled with zeros) and addr_valid
// tells whether the text was well formed; on a syntax error both halves are 0.
// The last character enters the queue at its accepting edge; the parser pops
// it once no held result is stalled and loads the result register at the edge
// on which it pops it. Throughput: one character per cycle while char_stall
// is low; texts follow each other with no gap.
// Reset clears the queue, the parser state and the result valid flag; with
// the queue empty, char_stall is low and the block is ready for a character.
// While result_stall holds a result, the parser keeps taking characters up
// to the next last character; the two-entry queue then fills and char_stall
// rises until the result is taken.
module ipv6_text_address_parser_top
    import ipv6p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low,
    output logic        addr_valid
);

    logic   tok_valid;
    token_t tok;
    logic   tok_pop;

    ipv6p_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .tok_pop    (tok_pop)
    );

    ipv6p_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .tok_pop      (tok_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .addr_high    (addr_high),
        .addr_low     (addr_low),
        .addr_valid   (addr_valid)
    );

endmodule
